// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/jebr_pkg.sv
// ---------------------------------------------------------------------------
// JPEG entropy bit reader package
// Action and status codes, field widths and the result word layout.
// ---------------------------------------------------------------------------
package jebr_pkg;

    localparam int ACTION_W = 3;
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 17;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 6;

    localparam logic [ACTION_W-1:0] ACT_PUSH    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_GET     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ALIGN   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_END     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STOP = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_00 = 8'h00;

    typedef struct packed {
        logic [HELD_W-1:0]          bits_held;
        logic [7:0]                 marker_code;
        logic                       marker_seen;
        logic [STATUS_W-1:0]        status;
        logic signed [VALUE_W-1:0]  value;
    } result_t;

endpackage

// File: rtl/jpeg_entropy_bit_reader_core.sv
// ---------------------------------------------------------------------------
// JPEG entropy bit reader core
// Unstuffs pushed segment bytes into a bit store and serves get/peek
// requests of up to MAX_FIELD_BITS bits, MSB first.
//
// Input channel s_*: one request word per handshake; s_tuser carries the
// action, s_tdata the byte, bit count and sign-extend flag.
// Output channel m_*: one result word for every request word.
// Each result is registered in the output register (or the skid register).
// Throughput: one request per cycle while s_tready is high; the store
// update and field extraction are a single shift-and-compare stage ahead
// of the result register.
// A two-deep result buffer (output register plus skid register) keeps
// s_tready high for one more word while m_tready is low; s_tready drops
// only once both entries are full.
// Reset (rst_n low) empties the store, clears the marker and end flags and
// drops any buffered results; a restart request does the same to the
// reader state without disturbing results already buffered.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jpeg_entropy_bit_reader_core #(
    parameter int STORE_BITS     = 32,
    parameter int MAX_FIELD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // data_byte[7:0], bit_count[12:8], sign_extend[13]
    input  logic [15:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // value[16:0], status[18:17], marker_seen[19], marker_code[27:20],
    // bits_held[33:28], zero[39:34]
    output logic [39:0] m_tdata
);

    localparam int SW = STORE_BITS;
    localparam int FB = MAX_FIELD_BITS;
    localparam int CW = $clog2(STORE_BITS + 1);
    localparam int VW = (FB + 1 > jebr_pkg::VALUE_W) ? FB + 1 : jebr_pkg::VALUE_W;
    localparam logic [CW-1:0] FULL_LIMIT = CW'(STORE_BITS - 8);
    localparam logic [jebr_pkg::COUNT_W-1:0] N_MAX = jebr_pkg::COUNT_W'(MAX_FIELD_BITS);

    logic [SW-1:0] store_reg, store_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ff_reg, ff_next;
    logic          mhit_reg, mhit_next;
    logic [7:0]    mbyte_reg, mbyte_next;
    logic          ended_reg, ended_next;

    logic               out_valid_reg, skid_valid_reg;
    jebr_pkg::result_t  out_reg, skid_reg, res;

    logic [jebr_pkg::ACTION_W-1:0] action;
    logic [7:0]                    data_byte;
    logic [jebr_pkg::COUNT_W-1:0]  bit_count, n_sat;
    logic                          sign_extend;

    logic [CW-1:0] n_ext, rem, pad;
    logic          have;
    logic [FB-1:0] fmask, ext_get, ext_pad;
    logic [SW-1:0] smask;
    logic [VW-1:0] val_w;
    logic [jebr_pkg::STATUS_W-1:0] status, short_st;

    logic accept, take;

    assign action      = s_tuser;
    assign data_byte   = s_tdata[7:0];
    assign bit_count   = s_tdata[12:8];
    assign sign_extend = s_tdata[13];

    assign n_sat    = (bit_count > N_MAX) ? N_MAX : bit_count;
    assign n_ext    = CW'(n_sat);
    assign have     = cnt_reg >= n_ext;
    assign rem      = cnt_reg - n_ext;
    assign pad      = n_ext - cnt_reg;
    assign fmask    = ~({FB{1'b1}} << n_sat);
    assign smask    = ~({SW{1'b1}} << rem);
    assign ext_get  = FB'(store_reg >> rem) & fmask;
    assign ext_pad  = FB'(store_reg << pad) & fmask;
    assign short_st = (mhit_reg || ended_reg) ? jebr_pkg::ST_STOP : jebr_pkg::ST_NEED;

    always_comb
    begin
        store_next = store_reg;
        cnt_next   = cnt_reg;
        ff_next    = ff_reg;
        mhit_next  = mhit_reg;
        mbyte_next = mbyte_reg;
        ended_next = ended_reg;
        val_w      = '0;
        status     = jebr_pkg::ST_OK;
        case (action)
            jebr_pkg::ACT_PUSH:
            begin
                if (mhit_reg || ended_reg)
                begin
                    status = jebr_pkg::ST_STOP;
                end
                else if (cnt_reg > FULL_LIMIT)
                begin
                    status = jebr_pkg::ST_FULL;
                end
                else if (ff_reg)
                begin
                    ff_next = 1'b0;
                    if (data_byte == jebr_pkg::BYTE_00)
                    begin
                        store_next = {store_reg[SW-9:0], jebr_pkg::BYTE_FF};
                        cnt_next   = cnt_reg + CW'(8);
                    end
                    else
                    begin
                        mhit_next  = 1'b1;
                        mbyte_next = data_byte;
                        status     = jebr_pkg::ST_STOP;
                    end
                end
                else if (data_byte == jebr_pkg::BYTE_FF)
                begin
                    ff_next = 1'b1;
                end
                else
                begin
                    store_next = {store_reg[SW-9:0], data_byte};
                    cnt_next   = cnt_reg + CW'(8);
                end
            end
            jebr_pkg::ACT_GET:
            begin
                if (n_sat != '0)
                begin
                    if (!have)
                    begin
                        status = short_st;
                    end
                    else
                    begin
                        cnt_next   = rem;
                        store_next = store_reg & smask;
                        if (sign_extend && (ext_get <= (fmask >> 1)))
                            val_w = VW'(ext_get) - VW'(fmask);
                        else
                            val_w = VW'(ext_get);
                    end
                end
            end
            jebr_pkg::ACT_PEEK:
            begin
                if (n_sat != '0)
                begin
                    if (!have)
                    begin
                        val_w  = VW'(ext_pad);
                        status = short_st;
                    end
                    else
                    begin
                        val_w = VW'(ext_get);
                    end
                end
            end
            jebr_pkg::ACT_ALIGN:
            begin
                store_next = '0;
                cnt_next   = '0;
            end
            jebr_pkg::ACT_END:
            begin
                ff_next    = 1'b0;
                ended_next = 1'b1;
            end
            jebr_pkg::ACT_RESTART:
            begin
                store_next = '0;
                cnt_next   = '0;
                ff_next    = 1'b0;
                mhit_next  = 1'b0;
                mbyte_next = '0;
                ended_next = 1'b0;
            end
            default:
            begin
                status = jebr_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        res.value       = val_w[jebr_pkg::VALUE_W-1:0];
        res.status      = status;
        res.marker_seen = mhit_next;
        res.marker_code = mbyte_next;
        res.bits_held   = jebr_pkg::HELD_W'(cnt_next);
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign take     = out_valid_reg && m_tready;
    assign m_tdata  = {6'b0, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            cnt_reg   <= '0;
            ff_reg    <= 1'b0;
            mhit_reg  <= 1'b0;
            mbyte_reg <= '0;
            ended_reg <= 1'b0;
        end
        else if (accept)
        begin
            store_reg <= store_next;
            cnt_reg   <= cnt_next;
            ff_reg    <= ff_next;
            mhit_reg  <= mhit_next;
            mbyte_reg <= mbyte_next;
            ended_reg <= ended_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else if (!accept)
                out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res;
        end
        else if (accept)
        begin
            if (!out_valid_reg)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CW'(STORE_BITS))
    `ASSERT_ALWAYS(a_marker_code, clk, rst_n, mhit_reg == (mbyte_reg != 8'h00))
    `ASSERT_IMPLIES(a_ff_live, clk, rst_n, ff_reg, !mhit_reg && !ended_reg)
    `ASSERT_IMPLIES(a_skid_order, clk, rst_n, skid_valid_reg, out_valid_reg)

endmodule
